[hdl/rcfr_pkg.sv]
// Shared types, constants and helper functions of the RC channel frame receiver.
`timescale 1ns / 1ps

package rcfr_pkg;

   // Request command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Response kinds
   localparam logic KIND_CHAN    = 1'b0;
   localparam logic KIND_CRC_ERR = 1'b1;

   // Frame layout
   localparam logic [7:0] SYNC_BYTE = 8'hC8;
   localparam logic [7:0] LEN_BYTE  = 8'd24;
   localparam logic [7:0] TYPE_BYTE = 8'h16;
   localparam logic [7:0] CRC_POLY  = 8'hD5;

   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_HUNT      = 5'd0;
   localparam logic [POS_W-1:0] POS_LEN       = 5'd1;
   localparam logic [POS_W-1:0] POS_TYPE      = 5'd2;
   localparam logic [POS_W-1:0] POS_PAY_FIRST = 5'd3;
   localparam logic [POS_W-1:0] POS_CRC       = 5'd25;

   // Channel unpacking
   localparam int CHANNELS      = 16;
   localparam int CHAN_IDX_W    = 4;
   localparam int RAW_W         = 11;
   localparam int VALUE_W       = 12;
   localparam int PAYLOAD_BYTES = 22;
   localparam int PAYLOAD_W     = PAYLOAD_BYTES * 8;
   localparam logic [CHAN_IDX_W-1:0] CHAN_LAST = CHAN_IDX_W'(CHANNELS - 1);

   // raw * 1000 / 1600 reduces exactly to raw * 5 / 8
   localparam int SCALE_NUM   = 5;
   localparam int SCALE_SHIFT = 3;
   localparam logic [VALUE_W-1:0] CHAN_OFFSET = 12'd880;

   // Configuration
   localparam int TIMEOUT_W = 16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;
   localparam int IDLE_COUNTER_WIDTH_DEFAULT = 16;

   typedef struct packed {
      logic                  accept;
      logic                  load_chan;
      logic                  load_err;
      logic [CHAN_IDX_W-1:0] chan_idx;
      logic                  chan_last;
   } ctrl_cmd_type;

   typedef struct packed {
      logic at_crc_byte;
      logic crc_match;
      logic is_byte;
      logic rsp_busy;
   } dp_stat_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [VALUE_W-1:0] scale_channel(input logic [RAW_W-1:0] raw);
      logic [RAW_W+2:0] prod;
      prod = (RAW_W+3)'(raw) * (RAW_W+3)'(SCALE_NUM);
      return VALUE_W'(prod >> SCALE_SHIFT) + CHAN_OFFSET;
   endfunction

endpackage

[hdl/rcfr_if.sv]
// Channel interfaces: request, response and CSR write channels.
`timescale 1ns / 1ps

interface rcfr_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] rx_byte;

   modport source (output valid, command, rx_byte, input ready);
   modport sink (input valid, command, rx_byte, output ready);
endinterface

interface rcfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [3:0]  channel_index;
   logic [11:0] channel_value;
   logic        last_of_frame;

   modport source (output valid, kind, channel_index, channel_value, last_of_frame,
                   input ready);
   modport sink (input valid, kind, channel_index, channel_value, last_of_frame,
                 output ready);
endinterface

interface rcfr_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[hdl/rcfr_ctrl.sv]
// Controller: request gating and channel emit sequencing.
`timescale 1ns / 1ps

module rcfr_ctrl
   import rcfr_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic {ST_ACCEPT, ST_EMIT} state_type;

   state_type             state_ff, state_in;
   logic [CHAN_IDX_W-1:0] cnt_ff, cnt_in;
   logic                  final_byte;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      // hold off the CRC byte while a response still occupies the output register
      req_ready  = (state_ff == ST_ACCEPT) && !(stat.rsp_busy && stat.at_crc_byte);
      cmd.accept = req_valid && req_ready;
      final_byte = cmd.accept && stat.is_byte && stat.at_crc_byte;
      case (state_ff)
         ST_ACCEPT: begin
            if (final_byte) begin
               if (stat.crc_match) begin
                  cmd.load_chan = 1'b1;
                  cmd.chan_idx  = '0;
                  cmd.chan_last = (CHAN_LAST == '0);
                  cnt_in        = CHAN_IDX_W'(1);
                  state_in      = ST_EMIT;
               end else begin
                  cmd.load_err = 1'b1;
               end
            end
         end
         ST_EMIT: begin
            if (!stat.rsp_busy) begin
               cmd.load_chan = 1'b1;
               cmd.chan_idx  = cnt_ff;
               cmd.chan_last = (cnt_ff == CHAN_LAST);
               cnt_in        = cnt_ff + 1'b1;
               if (cnt_ff == CHAN_LAST) begin
                  state_in = ST_ACCEPT;
               end
            end
         end
         default: begin
            state_in = ST_ACCEPT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[hdl/rcfr_dp.sv]
// Datapath: frame position, CRC, idle counter, payload shift line and output register.
`timescale 1ns / 1ps

module rcfr_dp
   import rcfr_pkg::*;
#(
   parameter int IDLE_COUNTER_WIDTH = IDLE_COUNTER_WIDTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [TIMEOUT_W-1:0]  csr_data,
   input  logic                  req_command,
   input  logic [7:0]            req_rx_byte,
   input  ctrl_cmd_type          cmd,
   output dp_stat_type           stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic                  rsp_kind,
   output logic [CHAN_IDX_W-1:0] rsp_channel_index,
   output logic [VALUE_W-1:0]    rsp_channel_value,
   output logic                  rsp_last_of_frame
);

   localparam int CMP_W = (IDLE_COUNTER_WIDTH > TIMEOUT_W) ? IDLE_COUNTER_WIDTH : TIMEOUT_W;

   logic [TIMEOUT_W-1:0]          timeout_ff;
   logic [POS_W-1:0]              pos_ff, pos_in;
   logic [7:0]                    crc_ff, crc_in;
   logic [IDLE_COUNTER_WIDTH-1:0] idle_ff, idle_in;
   logic [PAYLOAD_W-1:0]          pay_ff, pay_in;

   logic                          valid_ff, valid_in;
   logic                          kind_ff, kind_in;
   logic [CHAN_IDX_W-1:0]         idx_ff, idx_in;
   logic [VALUE_W-1:0]            value_ff, value_in;
   logic                          last_ff, last_in;

   always_comb begin
      stat.at_crc_byte = (pos_ff >= POS_CRC);
      stat.crc_match   = (req_rx_byte == crc_ff);
      stat.is_byte     = (req_command == CMD_BYTE);
      stat.rsp_busy    = valid_ff && !rsp_ready;
   end

   // frame tracking
   always_comb begin
      pos_in  = pos_ff;
      crc_in  = crc_ff;
      idle_in = idle_ff;
      pay_in  = pay_ff;
      if (cmd.accept) begin
         if (req_command == CMD_TICK) begin
            idle_in = (&idle_ff) ? idle_ff : idle_ff + 1'b1;
            if (CMP_W'(idle_in) > CMP_W'(timeout_ff)) begin
               pos_in = POS_HUNT;
            end
         end else begin
            idle_in = '0;
            case (pos_ff) inside
               POS_HUNT: begin
                  if (req_rx_byte == SYNC_BYTE) begin
                     pos_in = POS_LEN;
                     crc_in = '0;
                  end
               end
               POS_LEN: begin
                  pos_in = (req_rx_byte == LEN_BYTE) ? POS_TYPE : POS_HUNT;
               end
               POS_TYPE: begin
                  if (req_rx_byte == TYPE_BYTE) begin
                     crc_in = crc8_update(8'h00, req_rx_byte);
                     pos_in = POS_PAY_FIRST;
                  end else begin
                     pos_in = POS_HUNT;
                  end
               end
               [POS_PAY_FIRST:POS_CRC-1]: begin
                  // shift in from the top: first payload byte ends up at bit 0
                  pay_in = {req_rx_byte, pay_ff[PAYLOAD_W-1:8]};
                  crc_in = crc8_update(crc_ff, req_rx_byte);
                  pos_in = pos_ff + 1'b1;
               end
               default: begin
                  pos_in = POS_HUNT;
               end
            endcase
         end
      end
      if (cmd.load_chan) begin
         // advance to the next packed channel
         pay_in = pay_ff >> RAW_W;
      end
   end

   // output register
   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      kind_in  = kind_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      last_in  = last_ff;
      if (cmd.load_chan) begin
         valid_in = 1'b1;
         kind_in  = KIND_CHAN;
         idx_in   = cmd.chan_idx;
         value_in = scale_channel(pay_ff[RAW_W-1:0]);
         last_in  = cmd.chan_last;
      end else if (cmd.load_err) begin
         valid_in = 1'b1;
         kind_in  = KIND_CRC_ERR;
         idx_in   = '0;
         value_in = '0;
         last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
         pos_ff     <= POS_HUNT;
         crc_ff     <= '0;
         idle_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            timeout_ff <= csr_data;
         end
         pos_ff   <= pos_in;
         crc_ff   <= crc_in;
         idle_ff  <= idle_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pay_ff   <= pay_in;
      kind_ff  <= kind_in;
      idx_ff   <= idx_in;
      value_ff <= value_in;
      last_ff  <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_channel_index = idx_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_last_of_frame = last_ff;

endmodule

[hdl/rc_channel_frame_receiver_top.sv]
// Top level of the RC channel frame receiver.
`timescale 1ns / 1ps

//  channel | dir | payload                                               | handshake
//  req_ch  | in  | command, rx_byte                                      | valid/ready
//  rsp_ch  | out | kind, channel_index, channel_value, last_of_frame     | valid/ready
//  csr_ch  | in  | data (timeout_ticks)                                  | valid/ready
//
//  Bytes and ticks are taken one per cycle when ready; bytes move position and CRC, ticks
//  the idle count. A good CRC byte loads channel 0; channels 1 to 15 follow one per cycle
//  unless a response stalls, from the 176-bit payload shift line, holding off requests.
//  A bad CRC loads one error response and input continues. At the CRC position any
//  request waits while an earlier response is still stalled in the output register.
//  Synchronous reset; no clearing pass. CSR writes are always ready.

module rc_channel_frame_receiver_top
   import rcfr_pkg::*;
#(
   parameter int IDLE_COUNTER_WIDTH = IDLE_COUNTER_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   rcfr_req_if.sink   req_ch,
   rcfr_rsp_if.source rsp_ch,
   rcfr_csr_if.sink   csr_ch
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   assign csr_ch.ready = 1'b1;

   rcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   rcfr_dp #(
      .IDLE_COUNTER_WIDTH (IDLE_COUNTER_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_ch.valid),
      .csr_data          (csr_ch.data),
      .req_command       (req_ch.command),
      .req_rx_byte       (req_ch.rx_byte),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_ready         (rsp_ch.ready),
      .rsp_valid         (rsp_ch.valid),
      .rsp_kind          (rsp_ch.kind),
      .rsp_channel_index (rsp_ch.channel_index),
      .rsp_channel_value (rsp_ch.channel_value),
      .rsp_last_of_frame (rsp_ch.last_of_frame)
   );

   // a stalled response is never overwritten by a frame end
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready && stat.at_crc_byte |-> !req_ch.ready)
      else $error("CRC byte accepted while response stalled");

   // error responses are single, last, zero-index items
   a_err_shape : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind == KIND_CRC_ERR |->
         rsp_ch.last_of_frame && rsp_ch.channel_index == '0)
      else $error("malformed CRC error response");

   // channels follow in order without gaps
   a_chan_order : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_of_frame |=>
         rsp_ch.valid && rsp_ch.channel_index == $past(rsp_ch.channel_index) + 4'd1)
      else $error("channel sequence broken");

endmodule

[test/tb_top.sv]
// Self-checking testbench of the RC channel frame receiver: directed, timeout and random frames.
`timescale 1ns / 1ps

module tb_top;
   import rcfr_pkg::*;

   localparam int IDLE_W         = IDLE_COUNTER_WIDTH_DEFAULT;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int FRAME_BYTES    = 26;
   localparam int SCALE_MUL      = 1000;
   localparam int SCALE_DIV      = 1600;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic                  kind;
      logic [CHAN_IDX_W-1:0] index;
      logic [VALUE_W-1:0]    value;
      logic                  last;
   } rc_result_type;

   logic clock;
   logic reset;

   rcfr_req_if req_bus ();
   rcfr_rsp_if rsp_bus ();
   rcfr_csr_if csr_bus ();

   rc_channel_frame_receiver_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus),
      .csr_ch (csr_bus)
   );

   // Shadow of the decoder state
   logic [POS_W-1:0]     frame_pos;
   logic [7:0]           crc_acc;
   logic [PAYLOAD_W-1:0] payload_shadow;
   logic [IDLE_W-1:0]    idle_count;
   logic [TIMEOUT_W-1:0] timeout_limit;
   rc_result_type        pending_channels[$];

   int mismatch_count;
   int stall_cycles;
   int src_idle_pct;
   int snk_idle_pct;
   int sent_count;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc;
      for (int k = 7; k >= 0; k--) begin
         if (c[7] ^ data[k]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] frame_crc(input logic [PAYLOAD_W-1:0] pay);
      logic [7:0] c;
      c = crc8_step(8'h00, TYPE_BYTE);
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         c = crc8_step(c, pay[8*i +: 8]);
      end
      return c;
   endfunction

   function automatic logic [PAYLOAD_W-1:0] random_payload();
      logic [PAYLOAD_W-1:0] p;
      for (int i = 0; i < PAYLOAD_BYTES; i++) begin
         p[8*i +: 8] = 8'($urandom);
      end
      return p;
   endfunction

   // Advance the shadow decoder by one accepted request and queue the channels it yields.
   function automatic void decode_request(input logic cmd, input logic [7:0] data);
      rc_result_type r;
      int            raw;
      if (cmd == CMD_TICK) begin
         if (idle_count != '1) begin
            idle_count = idle_count + 1'b1;
         end
         if (idle_count > timeout_limit) begin
            frame_pos = POS_HUNT;
         end
         return;
      end
      idle_count = '0;
      case (frame_pos)
         POS_HUNT: begin
            if (data == SYNC_BYTE) begin
               frame_pos = POS_LEN;
               crc_acc   = 8'h00;
            end
         end
         POS_LEN: begin
            frame_pos = (data == LEN_BYTE) ? POS_TYPE : POS_HUNT;
         end
         POS_TYPE: begin
            if (data == TYPE_BYTE) begin
               crc_acc   = crc8_step(8'h00, data);
               frame_pos = POS_PAY_FIRST;
            end else begin
               frame_pos = POS_HUNT;
            end
         end
         POS_CRC: begin
            frame_pos = POS_HUNT;
            if (data != crc_acc) begin
               r.kind  = KIND_CRC_ERR;
               r.index = '0;
               r.value = '0;
               r.last  = 1'b1;
               pending_channels.push_back(r);
            end else begin
               for (int ch = 0; ch < CHANNELS; ch++) begin
                  raw     = int'(payload_shadow[ch*RAW_W +: RAW_W]);
                  r.kind  = KIND_CHAN;
                  r.index = CHAN_IDX_W'(ch);
                  r.value = VALUE_W'(raw * SCALE_MUL / SCALE_DIV) + CHAN_OFFSET;
                  r.last  = (ch == CHANNELS - 1);
                  pending_channels.push_back(r);
               end
            end
         end
         default: begin
            payload_shadow[8*(int'(frame_pos) - int'(POS_PAY_FIRST)) +: 8] = data;
            crc_acc   = crc8_step(crc_acc, data);
            frame_pos = frame_pos + 1'b1;
         end
      endcase
   endfunction

   function automatic void flag_mismatch(input string field, input logic [15:0] want_v,
                                         input logic [15:0] got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("%0t: response %s mismatch: expected %0h, got %0h", $realtime, field,
                  want_v, got_v);
      end
   endfunction

   task automatic send_request(input logic cmd, input logic [7:0] data);
      @(negedge clock);
      while ($urandom_range(0, 99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.rx_byte <= data;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      decode_request(cmd, data);
      sent_count++;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) begin
         send_request(CMD_TICK, 8'($urandom));
      end
   endtask

   // Send one frame; gap_len ticks go in before byte gap_at, random short tick runs elsewhere.
   task automatic send_frame(input logic [PAYLOAD_W-1:0] pay, input logic [7:0] crc_flip,
                             input int gap_at, input int gap_len, input int tick_pct);
      logic [7:0] data;
      logic [7:0] crc;
      crc = frame_crc(pay) ^ crc_flip;
      for (int k = 0; k < FRAME_BYTES; k++) begin
         if (k == gap_at) begin
            send_ticks(gap_len);
         end else if (k > 0 && $urandom_range(0, 99) < tick_pct) begin
            send_ticks($urandom_range(1, 4));
         end
         case (POS_W'(k))
            POS_HUNT: data = SYNC_BYTE;
            POS_LEN:  data = LEN_BYTE;
            POS_TYPE: data = TYPE_BYTE;
            POS_CRC:  data = crc;
            default:  data = pay[8*(k - int'(POS_PAY_FIRST)) +: 8];
         endcase
         send_request(CMD_BYTE, data);
      end
   endtask

   // Drop valid and hold until every queued channel has come back.
   task automatic wait_results_done();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_channels.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (csr_bus.ready !== 1'b1) begin
         @(posedge clock);
      end
      timeout_limit = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic test_directed_frames();
      src_idle_pct = 32;
      snk_idle_pct = 60;
      // all raw zero gives the lowest value; idle exactly at the reset timeout keeps the frame
      send_frame('0, 8'h00, 5, int'(TIMEOUT_RESET), 0);
      send_frame('1, 8'h00, -1, 0, 0);
      send_frame({11{16'hA55A}}, 8'h01, -1, 0, 0);
      // a sync in the length slot is dropped, not taken as a new sync
      send_request(CMD_BYTE, SYNC_BYTE);
      send_request(CMD_BYTE, SYNC_BYTE);
      send_request(CMD_BYTE, LEN_BYTE);
      send_request(CMD_BYTE, TYPE_BYTE);
      // wrong type byte
      send_request(CMD_BYTE, SYNC_BYTE);
      send_request(CMD_BYTE, LEN_BYTE);
      send_request(CMD_BYTE, TYPE_BYTE ^ 8'h01);
      send_frame(random_payload(), 8'h00, -1, 0, 0);
   endtask

   task automatic test_idle_timeout();
      src_idle_pct = 60;
      snk_idle_pct = 32;
      write_timeout(16'd1);
      send_frame(random_payload(), 8'h00, 10, 1, 0);
      send_frame(random_payload(), 8'h00, 10, 2, 0);
      write_timeout(16'd12);
      send_frame(random_payload(), 8'h00, 20, int'(timeout_limit) + 1, 0);
      send_frame(random_payload(), 8'h00, -1, 0, 0);
   endtask

   task automatic test_random_traffic(input int src_pct, input int snk_pct, input int n_items,
                                      input logic [TIMEOUT_W-1:0] timeout);
      int start;
      int pick;
      src_idle_pct = src_pct;
      snk_idle_pct = snk_pct;
      write_timeout(timeout);
      start = sent_count;
      while (sent_count - start < n_items) begin
         pick = $urandom_range(0, 19);
         if (pick < 12) begin
            send_frame(random_payload(), 8'h00, -1, 0, 15);
         end else if (pick < 14) begin
            send_frame(random_payload(), 8'($urandom_range(1, 255)), -1, 0, 10);
         end else if (pick < 16) begin
            // drop the frame partway, the rest arrives while hunting
            send_frame(random_payload(), 8'h00, $urandom_range(1, FRAME_BYTES - 1),
                       int'(timeout_limit) + $urandom_range(1, 4), 0);
         end else if (pick < 18) begin
            send_request(CMD_BYTE, SYNC_BYTE);
            if ($urandom_range(0, 1) != 0) begin
               send_request(CMD_BYTE, LEN_BYTE);
            end
            send_request(CMD_BYTE, 8'($urandom));
         end else if (pick == 18) begin
            repeat ($urandom_range(1, 6)) begin
               send_request(($urandom_range(0, 1) != 0) ? CMD_TICK : CMD_BYTE, 8'($urandom));
            end
         end else begin
            wait_results_done();
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
   end

   always @(posedge clock) begin : check_responses
      rc_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_channels.size() == 0) begin
            flag_mismatch("unexpected", 16'h0, {rsp_bus.kind, rsp_bus.channel_index,
                                                rsp_bus.channel_value[10:0]});
         end else begin
            want = pending_channels.pop_front();
            if (rsp_bus.kind !== want.kind) begin
               flag_mismatch("kind", 16'(want.kind), 16'(rsp_bus.kind));
            end
            if (rsp_bus.channel_index !== want.index) begin
               flag_mismatch("channel_index", 16'(want.index), 16'(rsp_bus.channel_index));
            end
            if (rsp_bus.channel_value !== want.value) begin
               flag_mismatch("channel_value", 16'(want.value), 16'(rsp_bus.channel_value));
            end
            if (rsp_bus.last_of_frame !== want.last) begin
               flag_mismatch("last_of_frame", 16'(want.last), 16'(rsp_bus.last_of_frame));
            end
         end
      end
   end

   // Give up when nothing moves on any channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
          || (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
          || (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_BYTE;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.data    = '0;
      mismatch_count  = 0;
      stall_cycles    = 0;
      src_idle_pct    = 0;
      snk_idle_pct    = 0;
      sent_count      = 0;
      frame_pos       = POS_HUNT;
      crc_acc         = 8'h00;
      payload_shadow  = '0;
      idle_count      = '0;
      timeout_limit   = TIMEOUT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_frames();
      test_idle_timeout();
      test_random_traffic(32, 60, 25, 16'd3);
      test_random_traffic(60, 32, 25, 16'($urandom_range(4, 40)));
      test_random_traffic(0, 0, 25, 16'd2);

      wait_results_done();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_channels.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[sim.f]
hdl/rcfr_pkg.sv
hdl/rcfr_if.sv
hdl/rcfr_ctrl.sv
hdl/rcfr_dp.sv
hdl/rc_channel_frame_receiver_top.sv
test/tb_top.sv
